FILE: src/priority_lease_authority_macros.svh
// Assertion macros shared by the lease authority RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PRIORITY_LEASE_AUTHORITY_MACROS_SVH
`define PRIORITY_LEASE_AUTHORITY_MACROS_SVH

// Expression must hold on every rising clock edge out of reset.
`define PLA_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PLA_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLA_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/plauth_pkg.sv
// Shared types, codes and a helper function for the lease authority.
// No dependencies; used by every module of the block.
package plauth_pkg;

    localparam int ID_W    = 16;
    localparam int TIME_W  = 48;
    localparam int LEASE_W = 32;
    localparam int DUR_W   = 32;
    localparam int ROLE_W  = 3;
    localparam int PRIO_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [DUR_W-1:0] MAX_LEASE_RST = DUR_W'(10000);
    localparam logic [DUR_W-1:0] MIN_LEASE_RST = DUR_W'(250);
    localparam logic [LEASE_W-1:0] LEASE_FIRST = LEASE_W'(1);

    typedef enum logic [2:0] {
        REQ_ACQUIRE = 3'd0,
        REQ_RENEW   = 3'd1,
        REQ_RELEASE = 3'd2,
        REQ_CHECK   = 3'd3,
        REQ_QUERY   = 3'd4
    } req_kind_t;

    typedef enum logic [2:0] {
        RSN_OK       = 3'd0,
        RSN_INVALID  = 3'd1,
        RSN_CONFLICT = 3'd2,
        RSN_EXPIRED  = 3'd3,
        RSN_NOT_HELD = 3'd4
    } reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LEASE = 2'd0,
        CFG_MIN_LEASE = 2'd1
    } cfg_idx_t;

    localparam logic [ROLE_W-1:0] ROLE_UNSPEC     = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_OBSERVER   = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_MAINTAINER = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_DCM        = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_SCRIPTED   = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_MANUAL     = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_SAFETY     = 3'd6;
    localparam logic [ROLE_W-1:0] ROLE_RESERVED   = 3'd7;

    localparam logic [PRIO_W-1:0] PRIO_SAFETY     = 6'd50;
    localparam logic [PRIO_W-1:0] PRIO_MANUAL     = 6'd40;
    localparam logic [PRIO_W-1:0] PRIO_SCRIPTED   = 6'd30;
    localparam logic [PRIO_W-1:0] PRIO_DCM        = 6'd20;
    localparam logic [PRIO_W-1:0] PRIO_MAINTAINER = 6'd10;
    localparam logic [PRIO_W-1:0] PRIO_NONE       = 6'd0;

    typedef struct packed {
        req_kind_t           kind;
        logic [ID_W-1:0]     session;
        logic [ID_W-1:0]     client;
        logic [ID_W-1:0]     vehicle;
        logic [ROLE_W-1:0]   role;
        logic [DUR_W-1:0]    requested;
        logic [LEASE_W-1:0]  lease_ref;
        logic [TIME_W-1:0]   now;
    } req_t;

    typedef struct packed {
        logic                held;
        logic [ID_W-1:0]     session;
        logic [ID_W-1:0]     client;
        logic [ROLE_W-1:0]   role;
        logic [LEASE_W-1:0]  lease;
        logic [TIME_W-1:0]   expiry;
    } holder_t;

    localparam holder_t HOLDER_EMPTY = '0;

    typedef struct packed {
        logic                ok;
        reason_t             reason;
        logic [LEASE_W-1:0]  lease;
        logic [ID_W-1:0]     client;
        logic [ROLE_W-1:0]   role;
        logic [TIME_W-1:0]   expiry;
    } res_t;

    typedef struct packed {
        logic [DUR_W-1:0] max_lease;
        logic [DUR_W-1:0] min_lease;
    } cfg_t;

    function automatic logic [PRIO_W-1:0] prio_of(input logic [ROLE_W-1:0] r);
        logic [PRIO_W-1:0] p;
        case (r)
            ROLE_SAFETY:     p = PRIO_SAFETY;
            ROLE_MANUAL:     p = PRIO_MANUAL;
            ROLE_SCRIPTED:   p = PRIO_SCRIPTED;
            ROLE_DCM:        p = PRIO_DCM;
            ROLE_MAINTAINER: p = PRIO_MAINTAINER;
            default:         p = PRIO_NONE;
        endcase
        return p;
    endfunction

endpackage

FILE: src/plauth_cfg.sv
// Configuration registers for the lease duration clamps.
// Depends on plauth_pkg.
module plauth_cfg
    import plauth_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_LEASE: cfg_next.max_lease = cfg_data;
                CFG_MIN_LEASE: cfg_next.min_lease = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_lease <= MAX_LEASE_RST;
            cfg_reg.min_lease <= MIN_LEASE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/plauth_holder.sv
// Lease holder state and lease identifier counter.
// Depends on plauth_pkg; next values come from plauth_decide.
module plauth_holder
    import plauth_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  holder_t            holder_in,
    input  logic [LEASE_W-1:0] next_lease_in,
    output holder_t            holder,
    output logic [LEASE_W-1:0] next_lease
);

    holder_t            holder_reg;
    holder_t            holder_next;
    logic [LEASE_W-1:0] next_lease_reg;
    logic [LEASE_W-1:0] next_lease_next;

    assign holder_next     = load ? holder_in : holder_reg;
    assign next_lease_next = load ? next_lease_in : next_lease_reg;
    assign holder          = holder_reg;
    assign next_lease      = next_lease_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holder_reg     <= HOLDER_EMPTY;
            next_lease_reg <= LEASE_FIRST;
        end
        else
        begin
            holder_reg     <= holder_next;
            next_lease_reg <= next_lease_next;
        end
    end

endmodule

FILE: src/plauth_decide.sv
// Decision logic for one request against the current holder.
// Depends on plauth_pkg; purely combinational.
module plauth_decide
    import plauth_pkg::*;
(
    input  req_t               req,
    input  cfg_t               cfg,
    input  holder_t            holder,
    input  logic [LEASE_W-1:0] next_lease,
    output holder_t            holder_next,
    output logic [LEASE_W-1:0] next_lease_next,
    output res_t               res
);

    logic               live;
    logic               same_sess;
    logic               lease_match;
    logic               bad_args;
    logic [DUR_W-1:0]   dur_lo;
    logic [DUR_W-1:0]   dur;
    logic [TIME_W:0]    end_sum;
    logic [TIME_W-1:0]  lease_end;
    logic [LEASE_W-1:0] lease_inc;
    logic               ok;
    reason_t            reason;
    logic               show;

    assign live        = holder.held && (holder.expiry > req.now);
    assign same_sess   = holder.session == req.session;
    assign lease_match = holder.lease == req.lease_ref;
    assign bad_args    = (req.session == '0) || (req.client == '0) || (req.vehicle == '0)
                      || (req.role inside {ROLE_UNSPEC, ROLE_OBSERVER, ROLE_RESERVED});

    // Raise to min first, then lower to max: max wins when clamps cross.
    assign dur_lo  = (req.requested < cfg.min_lease) ? cfg.min_lease : req.requested;
    assign dur     = (dur_lo > cfg.max_lease) ? cfg.max_lease : dur_lo;
    assign end_sum = {1'b0, req.now} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
    assign lease_end = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];

    // Skip zero on wrap.
    assign lease_inc = (next_lease == {LEASE_W{1'b1}}) ? LEASE_FIRST
                                                         : next_lease + LEASE_FIRST;

    always_comb
    begin
        holder_next     = holder;
        next_lease_next = next_lease;
        ok              = 1'b0;
        reason          = RSN_INVALID;
        show            = 1'b0;
        case (req.kind)
            REQ_ACQUIRE:
            begin
                if (bad_args)
                begin
                    reason = RSN_INVALID;
                end
                else if (live && !same_sess && (prio_of(req.role) <= prio_of(holder.role)))
                begin
                    reason = RSN_CONFLICT;
                end
                else
                begin
                    holder_next.held    = 1'b1;
                    holder_next.session = req.session;
                    holder_next.client  = req.client;
                    holder_next.role    = req.role;
                    holder_next.lease   = next_lease;
                    holder_next.expiry  = lease_end;
                    next_lease_next     = lease_inc;
                    ok                  = 1'b1;
                    reason              = RSN_OK;
                    show                = 1'b1;
                end
            end
            REQ_RENEW:
            begin
                if (!live || !same_sess || !lease_match)
                begin
                    holder_next = HOLDER_EMPTY;
                    reason      = RSN_EXPIRED;
                end
                else
                begin
                    holder_next.expiry = lease_end;
                    ok                 = 1'b1;
                    reason             = RSN_OK;
                    show               = 1'b1;
                end
            end
            REQ_RELEASE:
            begin
                // Release ignores expiry.
                if (!holder.held || !same_sess || !lease_match)
                begin
                    reason = RSN_NOT_HELD;
                end
                else
                begin
                    holder_next = HOLDER_EMPTY;
                    ok          = 1'b1;
                    reason      = RSN_OK;
                end
            end
            REQ_CHECK:
            begin
                if (!live)
                begin
                    reason = RSN_EXPIRED;
                end
                else if (!lease_match || (holder.client != req.client) || !same_sess)
                begin
                    reason = RSN_NOT_HELD;
                end
                else
                begin
                    ok     = 1'b1;
                    reason = RSN_OK;
                    show   = 1'b1;
                end
            end
            REQ_QUERY:
            begin
                if (!live)
                begin
                    reason = RSN_EXPIRED;
                end
                else
                begin
                    ok     = 1'b1;
                    reason = RSN_OK;
                    show   = 1'b1;
                end
            end
            default:
            begin
                reason = RSN_INVALID;
            end
        endcase
    end

    always_comb
    begin
        res.ok     = ok;
        res.reason = reason;
        res.lease  = show ? holder_next.lease  : '0;
        res.client = show ? holder_next.client : '0;
        res.role   = show ? holder_next.role   : '0;
        res.expiry = show ? holder_next.expiry : '0;
    end

endmodule

FILE: src/priority_lease_authority.sv
// Priority lease authority: single-holder lease with role priority and expiry.
// Pipeline: a request waits in the input register, is decided from there, and its
// result is registered in the result register; out_stall can hold both registers.
// Throughput: one request per cycle unless out_stall holds results; holder state
// updates as a request leaves the input register; the next request sees it next cycle.
// Reset: no holder, lease counter at 1, clamps at 10000 and 250 ms.
`include "priority_lease_authority_macros.svh"

module priority_lease_authority
    import plauth_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           req_type,
    input  logic [ID_W-1:0]      session_num,
    input  logic [ID_W-1:0]      client_num,
    input  logic [ID_W-1:0]      vehicle_num,
    input  logic [ROLE_W-1:0]    role,
    input  logic [DUR_W-1:0]     requested_ms,
    input  logic [LEASE_W-1:0]   lease_ref,
    input  logic [TIME_W-1:0]    now_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 ok,
    output logic [2:0]           reason,
    output logic [LEASE_W-1:0]   holder_lease,
    output logic [ID_W-1:0]      holder_client,
    output logic [ROLE_W-1:0]    holder_role,
    output logic [TIME_W-1:0]    expires_at
);

    cfg_t               cfg;
    holder_t            holder;
    holder_t            holder_upd;
    logic [LEASE_W-1:0] next_lease;
    logic [LEASE_W-1:0] next_lease_upd;
    res_t               dec_res;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    req_t               s1_req_reg;
    req_t               s1_req_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               res_reg;
    res_t               res_next;

    logic               in_fire;
    logic               s1_advance;

    // Advance the input register whenever the result register is free or draining.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_fire    = in_valid && !in_stall;

    always_comb
    begin
        s1_req_next = s1_req_reg;
        if (in_fire)
        begin
            s1_req_next.kind      = req_kind_t'(req_type);
            s1_req_next.session   = session_num;
            s1_req_next.client    = client_num;
            s1_req_next.vehicle   = vehicle_num;
            s1_req_next.role      = role;
            s1_req_next.requested = requested_ms;
            s1_req_next.lease_ref = lease_ref;
            s1_req_next.now       = now_ms;
        end
        s1_valid_next  = in_fire || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && out_stall);
        res_next       = s1_advance ? dec_res : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= s1_req_next;
        res_reg    <= res_next;
    end

    plauth_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plauth_decide u_decide (
        .req             (s1_req_reg),
        .cfg             (cfg),
        .holder          (holder),
        .next_lease      (next_lease),
        .holder_next     (holder_upd),
        .next_lease_next (next_lease_upd),
        .res             (dec_res)
    );

    plauth_holder u_holder (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_advance),
        .holder_in     (holder_upd),
        .next_lease_in (next_lease_upd),
        .holder        (holder),
        .next_lease    (next_lease)
    );

    assign out_valid     = out_valid_reg;
    assign ok            = res_reg.ok;
    assign reason        = res_reg.reason;
    assign holder_lease  = res_reg.lease;
    assign holder_client = res_reg.client;
    assign holder_role   = res_reg.role;
    assign expires_at    = res_reg.expiry;

    `PLA_CHECK(a_lease_nonzero, next_lease != '0, "lease counter holds zero")
    `PLA_IMPLIES(a_empty_clear, !holder.held, (holder.lease == '0) && (holder.expiry == '0), "empty holder keeps stale lease")
    `PLA_NEXT(a_grant_bumps, s1_advance && (s1_req_reg.kind == REQ_ACQUIRE) && dec_res.ok, next_lease != $past(next_lease), "grant did not advance lease counter")
    `PLA_IMPLIES(a_ok_reason, out_valid_reg && res_reg.ok, res_reg.reason == RSN_OK, "ok result with failure reason")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for priority_lease_authority: directed lease cases, then random
// request traffic under several clamp settings, with stalls and idle gaps on both sides.
// Depends on plauth_pkg and the priority_lease_authority RTL only.
module tb_top;
    import plauth_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SHOW_LIMIT  = 40;
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [ID_W-1:0]    session;
        logic [ID_W-1:0]    client;
        logic [ID_W-1:0]    vehicle;
        logic [ROLE_W-1:0]  role;
        logic [DUR_W-1:0]   requested;
        logic [LEASE_W-1:0] lease_ref;
        logic [TIME_W-1:0]  now;
    } lease_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           req_type = '0;
    logic [ID_W-1:0]      session_num = '0;
    logic [ID_W-1:0]      client_num = '0;
    logic [ID_W-1:0]      vehicle_num = '0;
    logic [ROLE_W-1:0]    role = '0;
    logic [DUR_W-1:0]     requested_ms = '0;
    logic [LEASE_W-1:0]   lease_ref = '0;
    logic [TIME_W-1:0]    now_ms = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 ok;
    logic [2:0]           reason;
    logic [LEASE_W-1:0]   holder_lease;
    logic [ID_W-1:0]      holder_client;
    logic [ROLE_W-1:0]    holder_role;
    logic [TIME_W-1:0]    expires_at;

    // Predicted lease state and clamp registers
    holder_t            owner = HOLDER_EMPTY;
    logic [LEASE_W-1:0] lease_counter = LEASE_FIRST;
    cfg_t               clamps = '{max_lease: MAX_LEASE_RST, min_lease: MIN_LEASE_RST};

    res_t               pending_answers[$];
    logic [TIME_W-1:0]  clock_ms = TIME_W'(1000);
    int unsigned        errors = 0;
    int unsigned        cycle_count = 0;
    int unsigned        rx_wait = 0;
    logic               tx_quiet = 1'b0;
    logic               rx_quiet = 1'b0;
    logic               rx_hold = 1'b0;

    priority_lease_authority dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .session_num(session_num), .client_num(client_num),
        .vehicle_num(vehicle_num), .role(role), .requested_ms(requested_ms),
        .lease_ref(lease_ref), .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .reason(reason), .holder_lease(holder_lease),
        .holder_client(holder_client), .holder_role(holder_role),
        .expires_at(expires_at)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned rank_of(input logic [ROLE_W-1:0] r);
        case (r)
            ROLE_SAFETY:     return PRIO_SAFETY;
            ROLE_MANUAL:     return PRIO_MANUAL;
            ROLE_SCRIPTED:   return PRIO_SCRIPTED;
            ROLE_DCM:        return PRIO_DCM;
            ROLE_MAINTAINER: return PRIO_MAINTAINER;
            default:         return PRIO_NONE;
        endcase
    endfunction

    // Clamp up to the minimum first, then down to the maximum; saturate the sum.
    function automatic logic [TIME_W-1:0] lease_end(input logic [TIME_W-1:0] now,
                                                    input logic [DUR_W-1:0] want);
        logic [DUR_W-1:0] span;
        logic [TIME_W:0]  sum;
        span = want;
        if (span < clamps.min_lease)
            span = clamps.min_lease;
        if (span > clamps.max_lease)
            span = clamps.max_lease;
        sum = {1'b0, now} + span;
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic res_t answer_with(input logic granted, input reason_t why,
                                         input logic show);
        res_t a;
        a = '0;
        a.ok = granted;
        a.reason = why;
        if (show)
        begin
            a.lease = owner.lease;
            a.client = owner.client;
            a.role = owner.role;
            a.expiry = owner.expiry;
        end
        return a;
    endfunction

    function automatic res_t decide_request(input lease_req_t r);
        logic live;
        logic matched;
        live = owner.held && (owner.expiry > r.now);
        matched = (owner.session == r.session) && (owner.lease == r.lease_ref);
        case (r.kind)
            REQ_ACQUIRE:
            begin
                if (r.session == '0 || r.client == '0 || r.vehicle == '0 ||
                    r.role == ROLE_UNSPEC || r.role == ROLE_OBSERVER ||
                    r.role == ROLE_RESERVED)
                    return answer_with(1'b0, RSN_INVALID, 1'b0);
                if (live && owner.session != r.session &&
                    rank_of(r.role) <= rank_of(owner.role))
                    return answer_with(1'b0, RSN_CONFLICT, 1'b0);
                owner.held = 1'b1;
                owner.session = r.session;
                owner.client = r.client;
                owner.role = r.role;
                owner.lease = lease_counter;
                owner.expiry = lease_end(r.now, r.requested);
                lease_counter = lease_counter + 1'b1;
                if (lease_counter == '0)
                    lease_counter = LEASE_FIRST;
                return answer_with(1'b1, RSN_OK, 1'b1);
            end
            REQ_RENEW:
            begin
                if (!live || !matched)
                begin
                    owner = HOLDER_EMPTY;
                    return answer_with(1'b0, RSN_EXPIRED, 1'b0);
                end
                owner.expiry = lease_end(r.now, r.requested);
                return answer_with(1'b1, RSN_OK, 1'b1);
            end
            REQ_RELEASE:
            begin
                // release ignores expiry
                if (!owner.held || !matched)
                    return answer_with(1'b0, RSN_NOT_HELD, 1'b0);
                owner = HOLDER_EMPTY;
                return answer_with(1'b1, RSN_OK, 1'b0);
            end
            REQ_CHECK:
            begin
                if (!live)
                    return answer_with(1'b0, RSN_EXPIRED, 1'b0);
                if (!matched || owner.client != r.client)
                    return answer_with(1'b0, RSN_NOT_HELD, 1'b0);
                return answer_with(1'b1, RSN_OK, 1'b1);
            end
            REQ_QUERY:
            begin
                if (!live)
                    return answer_with(1'b0, RSN_EXPIRED, 1'b0);
                return answer_with(1'b1, RSN_OK, 1'b1);
            end
            default:
                return answer_with(1'b0, RSN_INVALID, 1'b0);
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
        out_stall <= rx_hold || (rx_wait != 0);
        if (rx_wait != 0)
            rx_wait--;
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing actual ok=%0b reason=%0d",
                         $time, ok, reason);
            end
            else
            begin
                want = pending_answers.pop_front();
                compare_field("ok", want.ok, ok);
                compare_field("reason", want.reason, reason);
                compare_field("holder_lease", want.lease, holder_lease);
                compare_field("holder_client", want.client, holder_client);
                compare_field("holder_role", want.role, holder_role);
                compare_field("expires_at", want.expiry, expires_at);
            end
        end
    end

    // ---------------------------------------------------------------- request side

    task automatic send_request(input lease_req_t r);
        int unsigned gap;
        in_valid <= 1'b1;
        req_type <= r.kind;
        session_num <= r.session;
        client_num <= r.client;
        vehicle_num <= r.vehicle;
        role <= r.role;
        requested_ms <= r.requested;
        lease_ref <= r.lease_ref;
        now_ms <= r.now;
        do
            @(posedge clk);
        while (in_stall);
        pending_answers.push_back(decide_request(r));
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic lease_req_t request(input logic [2:0] kind,
                                           input logic [ID_W-1:0] sess,
                                           input logic [ID_W-1:0] cli,
                                           input logic [ID_W-1:0] veh,
                                           input logic [ROLE_W-1:0] who,
                                           input logic [DUR_W-1:0] want,
                                           input logic [LEASE_W-1:0] lease,
                                           input logic [TIME_W-1:0] now);
        lease_req_t r;
        r.kind = kind;
        r.session = sess;
        r.client = cli;
        r.vehicle = veh;
        r.role = who;
        r.requested = want;
        r.lease_ref = lease;
        r.now = now;
        return r;
    endfunction

    // Mostly well-formed traffic from a few sessions against the live holder.
    function automatic lease_req_t draw_request();
        lease_req_t  r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 59))
            0:       clock_ms = TIME_W'({$urandom, $urandom});
            1:       clock_ms = '1 - TIME_W'($urandom_range(0, 20000));
            default: clock_ms = clock_ms + TIME_W'($urandom_range(0, 400));
        endcase
        r.now = clock_ms;
        r.session = ID_W'($urandom_range(1, 4));
        r.client = ID_W'($urandom_range(1, 3));
        r.vehicle = ID_W'($urandom_range(1, 2));
        r.role = ($urandom_range(0, 9) == 0) ? ROLE_W'($urandom)
                                             : ROLE_W'($urandom_range(ROLE_MAINTAINER, ROLE_SAFETY));
        r.requested = ($urandom_range(0, 9) == 0) ? $urandom : DUR_W'($urandom_range(0, 3000));
        r.lease_ref = ($urandom_range(0, 6) == 0) ? lease_counter - LEASE_W'($urandom_range(1, 3))
                                                  : owner.lease;
        if (pick < 30)
            r.kind = REQ_ACQUIRE;
        else if (pick < 50)
            r.kind = REQ_RENEW;
        else if (pick < 62)
            r.kind = REQ_RELEASE;
        else if (pick < 76)
            r.kind = REQ_CHECK;
        else if (pick < 90)
            r.kind = REQ_QUERY;
        else if (pick < 94)
            r.kind = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        else
        begin
            r = lease_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            r.kind = 3'($urandom);
        end
        // aim most follow-up requests at the current holder
        if ((r.kind == REQ_RENEW || r.kind == REQ_RELEASE || r.kind == REQ_CHECK) &&
            pick < 94 && $urandom_range(0, 3) != 0)
        begin
            r.session = owner.session;
            r.client = owner.client;
        end
        return r;
    endfunction

    task automatic random_burst(input int unsigned count);
        repeat (count) send_request(draw_request());
    endtask

    // Drain all results, then let the pipeline empty before touching registers.
    task automatic settle();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MAX_LEASE: clamps.max_lease = value;
            CFG_MIN_LEASE: clamps.min_lease = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic hold_results(input int unsigned cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        logic [LEASE_W-1:0] stale;
        logic [TIME_W-1:0]  top;
        top = '1;
        // nothing held yet
        send_request(request(REQ_QUERY, 1, 1, 1, ROLE_DCM, 0, 0, 1000));
        send_request(request(REQ_CHECK, 1, 1, 1, ROLE_DCM, 0, 0, 1000));
        send_request(request(REQ_RELEASE, 1, 1, 1, ROLE_DCM, 0, 0, 1000));
        // invalid acquires
        send_request(request(REQ_ACQUIRE, 0, 1, 1, ROLE_DCM, 500, 0, 1000));
        send_request(request(REQ_ACQUIRE, 1, 0, 1, ROLE_DCM, 500, 0, 1000));
        send_request(request(REQ_ACQUIRE, 1, 1, 0, ROLE_DCM, 500, 0, 1000));
        send_request(request(REQ_ACQUIRE, 1, 1, 1, ROLE_UNSPEC, 500, 0, 1000));
        send_request(request(REQ_ACQUIRE, 1, 1, 1, ROLE_OBSERVER, 500, 0, 1000));
        send_request(request(REQ_ACQUIRE, 1, 1, 1, ROLE_RESERVED, 500, 0, 1000));
        // grant with duration raised to the minimum, then equal and lower priority lose
        send_request(request(REQ_ACQUIRE, '1, '1, '1, ROLE_DCM, 0, '1, 1000));
        send_request(request(REQ_ACQUIRE, 2, 2, 2, ROLE_DCM, 500, 0, 1100));
        send_request(request(REQ_ACQUIRE, 2, 2, 2, ROLE_MAINTAINER, 500, 0, 1100));
        // same session re-grants; duration lowered to the maximum
        send_request(request(REQ_ACQUIRE, '1, '1, '1, ROLE_SCRIPTED, '1, 0, 1000));
        send_request(request(REQ_CHECK, '1, '1, '1, ROLE_DCM, 0, owner.lease, 2000));
        send_request(request(REQ_CHECK, '1, 1, '1, ROLE_DCM, 0, owner.lease, 2000));
        send_request(request(REQ_RENEW, '1, '1, '1, ROLE_DCM, 700, owner.lease, 5000));
        stale = owner.lease;
        // preempt by a higher role, then the old holder's renew drops the lease
        send_request(request(REQ_ACQUIRE, 2, 2, 2, ROLE_SAFETY, 900, 0, 5000));
        send_request(request(REQ_RENEW, '1, '1, '1, ROLE_DCM, 700, stale, 5100));
        send_request(request(REQ_QUERY, 2, 2, 2, ROLE_DCM, 0, 0, 5100));
        // expiry saturates near the top of time
        send_request(request(REQ_ACQUIRE, 3, 3, 3, ROLE_MANUAL, '1, 0, top - 100));
        send_request(request(REQ_RELEASE, 3, 3, 3, ROLE_MANUAL, 0, owner.lease + 1'b1, top));
        send_request(request(REQ_RELEASE, 3, 3, 3, ROLE_MANUAL, 0, owner.lease, top));
        send_request(request(3'd5, 1, 1, 1, ROLE_DCM, 0, 0, 1000));
        send_request(request(3'd6, 1, 1, 1, ROLE_DCM, 0, 0, 1000));
        send_request(request(REQ_BAD_HI, 1, 1, 1, ROLE_DCM, 0, 0, 1000));
        // expiry at exactly now; release of an expired lease still succeeds
        send_request(request(REQ_ACQUIRE, 4, 4, 4, ROLE_MAINTAINER, 300, 0, 2000));
        send_request(request(REQ_QUERY, 4, 4, 4, ROLE_MAINTAINER, 0, 0, 2300));
        send_request(request(REQ_ACQUIRE, 5, 5, 5, ROLE_MAINTAINER, 300, 0, 2300));
        send_request(request(REQ_RELEASE, 5, 5, 5, ROLE_MAINTAINER, 0, owner.lease, 90000));
        settle();
    endtask

    task automatic test_short_clamp();
        write_reg(CFG_MAX_LEASE, DUR_W'(250));
        write_reg(CFG_MIN_LEASE, '0);
        random_burst(150);
        settle();
    endtask

    task automatic test_crossed_clamps();
        write_reg(CFG_MIN_LEASE, DUR_W'(5000));
        write_reg(CFG_MAX_LEASE, DUR_W'(300));
        // unused indexes must leave the clamps alone
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, '1);
        random_burst(150);
        settle();
    endtask

    task automatic test_wide_clamps();
        write_reg(CFG_MAX_LEASE, '1);
        write_reg(CFG_MIN_LEASE, '1);
        clock_ms = '1 - TIME_W'(32'd4000000000);
        random_burst(150);
        settle();
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_MAX_LEASE, MAX_LEASE_RST);
        write_reg(CFG_MIN_LEASE, MIN_LEASE_RST);
        clock_ms = TIME_W'(1000);
        tx_quiet <= 1'b1;
        fork
            hold_results(300);
        join_none
        random_burst(60);
        tx_quiet <= 1'b0;
        settle();
    endtask

    task automatic test_mixed_traffic();
        write_reg(CFG_MIN_LEASE, DUR_W'(100));
        write_reg(CFG_MAX_LEASE, DUR_W'(2000));
        tx_quiet <= 1'b1;
        rx_quiet <= 1'b1;
        random_burst(100);
        rx_quiet <= 1'b0;
        random_burst(100);
        tx_quiet <= 1'b0;
        random_burst(100);
        settle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_short_clamp();
        test_crossed_clamps();
        test_wide_clamps();
        test_output_backpressure();
        test_mixed_traffic();
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/plauth_pkg.sv
src/plauth_cfg.sv
src/plauth_holder.sv
src/plauth_decide.sv
src/priority_lease_authority.sv
test/tb_top.sv
